// File: rtl/dss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_pkg
// shared types and constants for the descending score sorter
// ----------------------------------------------------------------------------
package dss_pkg;

    localparam int SCORE_W   = 32;
    localparam int POS_W     = 6;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 40;
    localparam int M_PAD_W   = M_TDATA_W - SCORE_W - POS_W;

    typedef enum logic [0:0] {
        ST_LOAD  = 1'b0,
        ST_DRAIN = 1'b1
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic insert;
        logic pop;
    } dss_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic fill_next;
        logic last_one;
    } dss_status_t;

endpackage

// File: rtl/descending_score_sorter_unit.sv
`timescale 1ns / 1ps
// the first result shows in the cycle after the item that closes the set
// throughput: one input item per cycle while loading, one result per cycle
// while draining and m_tready is high
// no input is taken while a set is draining, set by the single row of cells
// reset: aresetn low clears the sequencer and the fill count; cells hold garbage
// ----------------------------------------------------------------------------
// descending_score_sorter_unit
// collects signed scores, tags each with its arrival position and streams the
// set back out highest score first, equal scores in arrival order
// ----------------------------------------------------------------------------
module descending_score_sorter_unit #(
    parameter int MAX_MEMBERS = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [dss_pkg::S_TDATA_W-1:0]   s_tdata,   // [31:0] score_in
    input  logic                            s_tlast,   // end_of_set
    // result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dss_pkg::M_TDATA_W-1:0]   m_tdata,   // [31:0] score_out, [37:32] origin_position
    output logic                            m_tlast    // run_end
);

    dss_pkg::dss_cmd_t                  cmd;
    dss_pkg::dss_status_t               status;
    logic signed [dss_pkg::SCORE_W-1:0] head_score;
    logic        [dss_pkg::POS_W-1:0]   head_pos;

    // sequencer: loads until the set closes, then drains the row
    dss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // sorted row: parallel compare against every cell, shift-in on insert,
    // shift towards the head on every result taken
    dss_datapath #(
        .MAX_MEMBERS (MAX_MEMBERS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .score_in   ($signed(s_tdata[dss_pkg::SCORE_W-1:0])),
        .cmd        (cmd),
        .status     (status),
        .head_score (head_score),
        .head_pos   (head_pos)
    );

    // head cell is a register, so the result leaves straight from flops
    assign m_tdata = {{dss_pkg::M_PAD_W{1'b0}}, head_pos, head_score};
    // the final result is the one taken while a single entry remains
    assign m_tlast = status.last_one;

`ifndef SYNTH
    // never loading and draining at once
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("sorter loading while draining");

    // a closing item starts the drain on the next cycle
    a_drain_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> m_tvalid)
        else $error("drain did not start after closing item");

    // after the final result the block returns to loading
    a_drain_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
        else $error("sorter did not return to loading");

    // results within a run never rise
    a_descending: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=>
            ($signed(m_tdata[dss_pkg::SCORE_W-1:0]) <=
             $signed($past(m_tdata[dss_pkg::SCORE_W-1:0]))))
        else $error("result order not descending");
`endif

endmodule

// File: rtl/dss_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_ctrl
// load / drain sequencer for the sorter
// ----------------------------------------------------------------------------
module dss_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  dss_pkg::dss_status_t status,
    output dss_pkg::dss_cmd_t    cmd
);

    dss_pkg::state_t state_reg;
    dss_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dss_pkg::ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        cmd.insert = 1'b0;
        cmd.pop    = 1'b0;
        case (state_reg)
            dss_pkg::ST_LOAD: begin
                s_tready   = 1'b1;
                cmd.insert = s_tvalid;
                // a marked item or the one that fills the row closes the set
                if (s_tvalid && (s_tlast || status.fill_next)) begin
                    state_next = dss_pkg::ST_DRAIN;
                end
            end
            dss_pkg::ST_DRAIN: begin
                m_tvalid = 1'b1;
                cmd.pop  = m_tready;
                if (m_tready && status.last_one) begin
                    state_next = dss_pkg::ST_LOAD;
                end
            end
            default: begin
                state_next = dss_pkg::ST_LOAD;
            end
        endcase
    end

endmodule

// File: rtl/dss_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_datapath
// insertion row of score / position cells, kept sorted highest first
// ----------------------------------------------------------------------------
module dss_datapath #(
    parameter int MAX_MEMBERS = 64
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic signed [dss_pkg::SCORE_W-1:0] score_in,
    input  dss_pkg::dss_cmd_t                  cmd,
    output dss_pkg::dss_status_t               status,
    output logic signed [dss_pkg::SCORE_W-1:0] head_score,
    output logic        [dss_pkg::POS_W-1:0]   head_pos
);

    localparam int CNT_W = $clog2(MAX_MEMBERS + 1);

    logic signed [dss_pkg::SCORE_W-1:0] score_reg [MAX_MEMBERS];
    logic        [dss_pkg::POS_W-1:0]   pos_reg   [MAX_MEMBERS];
    logic        [CNT_W-1:0]            count_reg;
    logic        [CNT_W-1:0]            count_next;
    logic        [MAX_MEMBERS-1:0]      below;
    logic        [dss_pkg::POS_W-1:0]   new_pos;

    // empty cells count as below the new score, so the row fills in order
    always_comb begin
        for (int i = 0; i < MAX_MEMBERS; i++) begin
            below[i] = (CNT_W'(i) >= count_reg) || (score_in > score_reg[i]);
        end
    end

    assign new_pos = dss_pkg::POS_W'(count_reg);

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_MEMBERS; i++) begin
            if (cmd.insert) begin
                if (i == 0) begin
                    if (below[0]) begin
                        score_reg[0] <= score_in;
                        pos_reg[0]   <= new_pos;
                    end
                end else if (below[i - 1]) begin
                    score_reg[i] <= score_reg[i - 1];
                    pos_reg[i]   <= pos_reg[i - 1];
                end else if (below[i]) begin
                    score_reg[i] <= score_in;
                    pos_reg[i]   <= new_pos;
                end
            end else if (cmd.pop && (i < MAX_MEMBERS - 1)) begin
                score_reg[i] <= score_reg[i + 1];
                pos_reg[i]   <= pos_reg[i + 1];
            end
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.insert) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.pop) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign status.fill_next = (count_reg == CNT_W'(MAX_MEMBERS - 1));
    assign status.last_one  = (count_reg == CNT_W'(1));
    assign head_score       = score_reg[0];
    assign head_pos         = pos_reg[0];

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// score sets are fed to the sorter, first from a short table and then at
// random, and each sorted result is checked against a behavioural ranking
// ----------------------------------------------------------------------------
module tb;

    localparam int MEMBERS      = 64;
    localparam int RANDOM_ITEMS = 136;
    localparam int IDLE_LIMIT   = 2000;
    localparam int TABLE_ROWS   = 24;

    // one sorted result as it should leave the block
    typedef struct packed {
        logic [dss_pkg::SCORE_W-1:0] score;
        logic [dss_pkg::POS_W-1:0]   origin;
        logic                        run_end;
    } ranked_t;

    // one table row; want is only used where typed is set
    typedef struct packed {
        logic [dss_pkg::SCORE_W-1:0] score;
        logic                        last;
        logic                        typed;
        ranked_t                     want;
    } stim_row_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [dss_pkg::S_TDATA_W-1:0] s_tdata;
    logic                          s_tlast;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [dss_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          m_tlast;

    // behavioural copy of the sorted store
    logic [dss_pkg::SCORE_W-1:0] held_score [MEMBERS];
    logic [dss_pkg::POS_W-1:0]   held_origin [MEMBERS];
    int                          held_count;

    ranked_t ranked_q[$];
    int      err_count   = 0;
    int      idle_cycles = 0;
    bit      source_calm;
    bit      sink_calm   = 1'b0;
    int      sink_stall  = 0;

    // single-score sets are typed in, the rest come from the ranking
    stim_row_t score_table [TABLE_ROWS] = '{
        '{32'h7FFF_FFFF, 1'b1, 1'b1, '{32'h7FFF_FFFF, 6'd0, 1'b1}},
        '{32'h8000_0000, 1'b1, 1'b1, '{32'h8000_0000, 6'd0, 1'b1}},
        '{32'h0000_0000, 1'b1, 1'b1, '{32'h0000_0000, 6'd0, 1'b1}},
        '{32'hFFFF_FFFF, 1'b1, 1'b1, '{32'hFFFF_FFFF, 6'd0, 1'b1}},
        // mixed extremes with a repeated score
        '{32'd5,         1'b0, 1'b0, '0},
        '{32'hFFFF_FFFD, 1'b0, 1'b0, '0},
        '{32'd5,         1'b0, 1'b0, '0},
        '{32'h8000_0000, 1'b0, 1'b0, '0},
        '{32'h7FFF_FFFF, 1'b1, 1'b0, '0},
        // all equal, must leave in arrival order
        '{32'd7,         1'b0, 1'b0, '0},
        '{32'd7,         1'b0, 1'b0, '0},
        '{32'd7,         1'b0, 1'b0, '0},
        '{32'd7,         1'b1, 1'b0, '0},
        // rising scores, each one goes to the head
        '{32'd1,         1'b0, 1'b0, '0},
        '{32'd2,         1'b0, 1'b0, '0},
        '{32'd3,         1'b0, 1'b0, '0},
        '{32'd4,         1'b1, 1'b0, '0},
        // falling scores, each one goes to the tail
        '{32'd3,         1'b0, 1'b0, '0},
        '{32'd2,         1'b0, 1'b0, '0},
        '{32'd1,         1'b1, 1'b0, '0},
        // sign boundary and alternating bit patterns
        '{32'h8000_0001, 1'b0, 1'b0, '0},
        '{32'hAAAA_AAAA, 1'b0, 1'b0, '0},
        '{32'h5555_5555, 1'b0, 1'b0, '0},
        '{32'h0000_0001, 1'b1, 1'b0, '0}
    };

    descending_score_sorter_unit #(
        .MAX_MEMBERS (MEMBERS)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            return $urandom_range(1, 3);
        else if (roll < 95)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    // full range, a narrow band that repeats often, or an extreme
    function automatic logic [dss_pkg::SCORE_W-1:0] draw_score();
        case ($urandom_range(0, 9))
            0, 1: return 32'($urandom_range(0, 6)) - 32'd3;
            2: begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // insert one score after every held score >= it; on the closing item
    // the whole run is queued as expected results if publish is set
    task automatic rank_score(input logic [dss_pkg::SCORE_W-1:0] score,
                              input logic last, input bit publish);
        int slot;
        int i;
        bit found;
        ranked_t r;
        slot  = held_count;
        found = 1'b0;
        for (i = 0; i < held_count; i++) begin
            if (!found && $signed(held_score[i]) < $signed(score)) begin
                slot  = i;
                found = 1'b1;
            end
        end
        for (i = held_count; i > slot; i--) begin
            held_score[i]  = held_score[i-1];
            held_origin[i] = held_origin[i-1];
        end
        held_score[slot]  = score;
        held_origin[slot] = dss_pkg::POS_W'(held_count);
        held_count++;
        if (last || held_count == MEMBERS) begin
            if (publish) begin
                for (i = 0; i < held_count; i++) begin
                    r.score   = held_score[i];
                    r.origin  = held_origin[i];
                    r.run_end = (i == held_count - 1);
                    ranked_q.push_back(r);
                end
            end
            held_count = 0;
        end
    endtask

    // present one item at the falling edge and hold it until taken
    task automatic send_score(input logic [dss_pkg::SCORE_W-1:0] score,
                              input logic last);
        int gap;
        if ($urandom_range(0, 19) == 0)
            source_calm = !source_calm;
        gap = (!source_calm && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            s_tdata  = $urandom;
            s_tlast  = 1'($urandom_range(0, 1));
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = score;
        s_tlast  = last;
        do @(posedge aclk); while (!s_tready);
    endtask

    // result side back-pressure
    always @(negedge aclk) begin
        if ($urandom_range(0, 99) == 0)
            sink_calm = !sink_calm;
        if (sink_stall > 0) begin
            m_tready   = 1'b0;
            sink_stall = sink_stall - 1;
        end else begin
            m_tready = 1'b1;
            if (!sink_calm && $urandom_range(0, 3) == 0)
                sink_stall = pick_gap();
        end
    end

    // compare every taken result with the oldest expectation
    always @(posedge aclk) begin
        ranked_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (ranked_q.size() == 0) begin
                if (err_count < 10)
                    $display("unexpected result: score %0d origin %0d end %0b",
                             $signed(m_tdata[dss_pkg::SCORE_W-1:0]),
                             m_tdata[dss_pkg::SCORE_W +: dss_pkg::POS_W], m_tlast);
                err_count++;
            end else begin
                want = ranked_q.pop_front();
                if (m_tdata[dss_pkg::SCORE_W-1:0] !== want.score ||
                    m_tdata[dss_pkg::SCORE_W +: dss_pkg::POS_W] !== want.origin ||
                    m_tlast !== want.run_end) begin
                    if (err_count < 10)
                        $display("mismatch: expected score %0d origin %0d end %0b, %s %0d %0d %0b",
                                 $signed(want.score), want.origin, want.run_end, "got",
                                 $signed(m_tdata[dss_pkg::SCORE_W-1:0]),
                                 m_tdata[dss_pkg::SCORE_W +: dss_pkg::POS_W], m_tlast);
                    err_count++;
                end
            end
        end
    end

    // give up when neither side has moved for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout with %0d results outstanding", ranked_q.size());
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial begin
        int row;
        int sent;
        int set_len;
        int k;
        logic closing;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        aresetn     = 1'b0;
        held_count  = 0;
        source_calm = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (row = 0; row < TABLE_ROWS; row++) begin
            send_score(score_table[row].score, score_table[row].last);
            if (score_table[row].typed) begin
                rank_score(score_table[row].score, score_table[row].last, 1'b0);
                ranked_q.push_back(score_table[row].want);
            end else begin
                rank_score(score_table[row].score, score_table[row].last, 1'b1);
            end
        end

        // a full store with no end mark closes the set by itself
        sent = 0;
        for (k = 0; k < MEMBERS; k++) begin
            send_score(draw_score(), 1'b0);
            rank_score(s_tdata, 1'b0, 1'b1);
            sent++;
        end

        // then mostly short sets, some middling and a few full ones
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 19))
                0, 1: set_len = MEMBERS;
                2, 3, 4: set_len = $urandom_range(9, 40);
                default: set_len = $urandom_range(1, 8);
            endcase
            if (set_len > RANDOM_ITEMS - sent)
                set_len = RANDOM_ITEMS - sent;
            for (k = 0; k < set_len; k++) begin
                if (k != set_len - 1)
                    closing = 1'b0;
                else if (set_len == MEMBERS)
                    closing = 1'($urandom_range(0, 1));
                else
                    closing = 1'b1;
                send_score(draw_score(), closing);
                rank_score(s_tdata, closing, 1'b1);
                sent++;
            end
        end

        @(negedge aclk);
        s_tvalid = 1'b0;

        // drain, then a short quiet spell to catch stray results
        while (ranked_q.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (err_count == 0 && ranked_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
